@@ design/bpa_pkg.sv @@
package bpa_pkg;

   localparam int ADDR_W    = 48;
   localparam int COUNT_W   = 13;
   localparam int MODE_W    = 2;
   localparam int SHIFT_W   = 5;
   localparam int MAXO_W    = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

   localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_PAGE_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_ADDR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ORDER  = 2'd2;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_PREP,
      ST_SHIFT,
      ST_ORDER,
      ST_SEARCH,
      ST_TAKE_RD,
      ST_TAKE_WR,
      ST_SPLIT,
      ST_SPLIT_CHK,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_IDX_SUB,
      ST_IDX_SHIFT,
      ST_TAG_RD,
      ST_TAG_CHK,
      ST_TAG_RD2,
      ST_TAG_CHK2,
      ST_PB_START,
      ST_PB_RD,
      ST_PB_CHK,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_PREP,
      CMD_SHIFT,
      CMD_ORDER_STEP,
      CMD_SET_K,
      CMD_SEARCH_NEXT,
      CMD_SEARCH_HIT,
      CMD_TAKE_RD,
      CMD_TAKE_WR,
      CMD_SPLIT_STEP,
      CMD_PUSH_A,
      CMD_PUSH_B,
      CMD_IDX_SUB,
      CMD_IDX_SHIFT,
      CMD_TAG_RD,
      CMD_ALIGN,
      CMD_K_LOAD,
      CMD_K_ZERO,
      CMD_PB_START,
      CMD_PB_RD,
      CMD_PB_MERGE,
      CMD_PB_SET,
      CMD_RES_OK,
      CMD_FAIL,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic              clear_last;
      logic              v_zero;
      logic              j_at_top;
      logic              j_eq_k;
      logic              head_ne;
      logic              idx_ok;
      logic              tag_free;
      logic              merge_ok;
      logic              pb_stop;
      logic              bud_ok;
      logic              out_free;
      logic [MODE_W-1:0] mode;
   } status_type;

endpackage

@@ design/bpa_req_if.sv @@
interface bpa_req_if;
   import bpa_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ADDR_W-1:0] request_bytes;
   logic [ADDR_W-1:0] address;
   modport source (output valid, mode, request_bytes, address, input ready);
   modport sink   (input valid, mode, request_bytes, address, output ready);
endinterface

@@ design/bpa_rsp_if.sv @@
interface bpa_rsp_if;
   import bpa_pkg::*;
   logic               valid;
   logic               ready;
   logic               status;
   logic [ADDR_W-1:0]  granted_address;
   logic [ADDR_W-1:0]  freed_bytes;
   logic [COUNT_W-1:0] free_pages;
   modport source (output valid, status, granted_address, freed_bytes, free_pages,
                   input ready);
   modport sink   (input valid, status, granted_address, freed_bytes, free_pages,
                   output ready);
endinterface

@@ design/bpa_csr_if.sv @@
interface bpa_csr_if;
   import bpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [ADDR_W-1:0]    wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ design/buddy_page_allocator.sv @@
// buddy page allocator over NUM_PAGES pages of 2^page_shift bytes from base_address.
// a req transaction is a reserve, a free, an add-page or an unknown mode; each one gives
// exactly one rsp transaction. after reset a clearing pass marks every page reserved,
// during which no request is taken (csr writes are taken at all times).
// one request at a time: a reserve works out its order k from the size, probes the free
// lists from order k up and splits the block it takes back down to k (a split whose upper
// buddy lies past the last page pushes nothing); a free or an add-page merges upward with
// free buddies, and an ignored free or add-page or an unknown mode replies without
// touching the lists. the merge walk reads the page table once per step. the next
// request can be taken in the cycle after the result is loaded; the result sits in an
// output register, so a new request is taken while it waits
module buddy_page_allocator #(
   parameter int NUM_PAGES = 4096,
   parameter int MAX_ORDER = 12
) (
   input logic       clock,
   input logic       reset,
   bpa_req_if.sink   req_port,
   bpa_rsp_if.source rsp_port,
   bpa_csr_if.sink   csr_port
);
   import bpa_pkg::*;

   cmd_type    cmd;
   status_type status;

   // csr writes are always taken
   assign csr_port.ready = 1'b1;

   // sequencer: steps through the states of the order, split and merge walks
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // page table memories, list heads, counters and the result register
   bpa_datapath #(
      .NUM_PAGES (NUM_PAGES),
      .MAX_ORDER (MAX_ORDER)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_port.mode),
      .req_request_bytes   (req_port.request_bytes),
      .req_address         (req_port.address),
      .csr_valid           (csr_port.valid),
      .csr_reg_index       (csr_port.reg_index),
      .csr_wdata           (csr_port.wdata),
      .rsp_valid           (rsp_port.valid),
      .rsp_ready           (rsp_port.ready),
      .rsp_status          (rsp_port.status),
      .rsp_granted_address (rsp_port.granted_address),
      .rsp_freed_bytes     (rsp_port.freed_bytes),
      .rsp_free_pages      (rsp_port.free_pages)
   );
endmodule

@@ design/bpa_ram.sv @@
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ design/bpa_ctrl.sv @@
module bpa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bpa_pkg::status_type status,
   output bpa_pkg::cmd_type    cmd
);
   import bpa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            unique case (status.mode) inside
               MODE_RESERVE:        state_in = ST_PREP;
               MODE_FREE, MODE_ADD: state_in = ST_IDX_SUB;
               default:             state_in = ST_DONE;
            endcase
         end
         ST_PREP:      state_in = ST_SHIFT;
         ST_SHIFT:     state_in = ST_ORDER;
         ST_ORDER: begin
            if (status.v_zero) state_in = ST_SEARCH;
            else if (status.j_at_top) state_in = ST_DONE;
         end
         ST_SEARCH: begin
            if (status.head_ne) state_in = ST_TAKE_RD;
            else if (status.j_at_top) state_in = ST_DONE;
         end
         ST_TAKE_RD:   state_in = ST_TAKE_WR;
         ST_TAKE_WR:   state_in = ST_SPLIT;
         ST_SPLIT: begin
            if (status.j_eq_k) state_in = ST_DONE;
            else state_in = ST_SPLIT_CHK;
         end
         ST_SPLIT_CHK: state_in = status.bud_ok ? ST_PUSH_A : ST_SPLIT;
         ST_PUSH_A:    state_in = ST_PUSH_B;
         ST_PUSH_B:    state_in = (status.mode == MODE_RESERVE) ? ST_SPLIT : ST_DONE;
         ST_IDX_SUB:   state_in = ST_IDX_SHIFT;
         ST_IDX_SHIFT: state_in = ST_TAG_RD;
         ST_TAG_RD:    state_in = status.idx_ok ? ST_TAG_CHK : ST_DONE;
         ST_TAG_CHK: begin
            if (status.tag_free) state_in = ST_DONE;
            else if (status.mode == MODE_FREE) state_in = ST_TAG_RD2;
            else state_in = ST_PB_START;
         end
         ST_TAG_RD2:   state_in = ST_TAG_CHK2;
         ST_TAG_CHK2:  state_in = status.tag_free ? ST_DONE : ST_PB_START;
         ST_PB_START:  state_in = ST_PB_RD;
         ST_PB_RD:     state_in = status.pb_stop ? ST_PUSH_A : ST_PB_CHK;
         ST_PB_CHK:    state_in = status.merge_ok ? ST_PB_RD : ST_PUSH_A;
         ST_DONE:      if (status.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:     cmd = CMD_CLEAR;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = CMD_LOAD;
         end
         ST_DISPATCH:  cmd = CMD_NONE;
         ST_PREP:      cmd = CMD_PREP;
         ST_SHIFT:     cmd = CMD_SHIFT;
         ST_ORDER: begin
            if (status.v_zero) cmd = CMD_SET_K;
            else if (status.j_at_top) cmd = CMD_FAIL;
            else cmd = CMD_ORDER_STEP;
         end
         ST_SEARCH: begin
            if (status.head_ne) cmd = CMD_SEARCH_HIT;
            else if (status.j_at_top) cmd = CMD_FAIL;
            else cmd = CMD_SEARCH_NEXT;
         end
         ST_TAKE_RD:   cmd = CMD_TAKE_RD;
         ST_TAKE_WR:   cmd = CMD_TAKE_WR;
         ST_SPLIT:     cmd = status.j_eq_k ? CMD_RES_OK : CMD_SPLIT_STEP;
         ST_SPLIT_CHK: cmd = CMD_NONE;
         ST_PUSH_A:    cmd = CMD_PUSH_A;
         ST_PUSH_B:    cmd = CMD_PUSH_B;
         ST_IDX_SUB:   cmd = CMD_IDX_SUB;
         ST_IDX_SHIFT: cmd = CMD_IDX_SHIFT;
         ST_TAG_RD:    if (status.idx_ok) cmd = CMD_TAG_RD;
         ST_TAG_CHK: begin
            if (!status.tag_free) begin
               cmd = (status.mode == MODE_FREE) ? CMD_ALIGN : CMD_K_ZERO;
            end
         end
         ST_TAG_RD2:   cmd = CMD_TAG_RD;
         ST_TAG_CHK2:  if (!status.tag_free) cmd = CMD_K_LOAD;
         ST_PB_START:  cmd = CMD_PB_START;
         ST_PB_RD:     cmd = status.pb_stop ? CMD_PB_SET : CMD_PB_RD;
         ST_PB_CHK:    cmd = status.merge_ok ? CMD_PB_MERGE : CMD_PB_SET;
         ST_DONE:      if (status.out_free) cmd = CMD_EMIT;
         default:      cmd = CMD_NONE;
      endcase
   end
endmodule

@@ design/bpa_datapath.sv @@
module bpa_datapath #(
   parameter int NUM_PAGES = 4096,
   parameter int MAX_ORDER = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bpa_pkg::cmd_type                     cmd,
   output bpa_pkg::status_type                  status,
   input  logic [bpa_pkg::MODE_W-1:0]           req_mode,
   input  logic [bpa_pkg::ADDR_W-1:0]           req_request_bytes,
   input  logic [bpa_pkg::ADDR_W-1:0]           req_address,
   input  logic                                 csr_valid,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]        csr_reg_index,
   input  logic [bpa_pkg::ADDR_W-1:0]           csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_status,
   output logic [bpa_pkg::ADDR_W-1:0]           rsp_granted_address,
   output logic [bpa_pkg::ADDR_W-1:0]           rsp_freed_bytes,
   output logic [bpa_pkg::COUNT_W-1:0]          rsp_free_pages
);
   import bpa_pkg::*;

   localparam int PW = $clog2(NUM_PAGES);
   localparam int OW = $clog2(MAX_ORDER + 1);
   localparam int NW = $clog2(NUM_PAGES + MAX_ORDER + 1);
   localparam int BW = ((PW > MAX_ORDER) ? PW : MAX_ORDER) + 1;
   localparam int TW = OW + 1;
   localparam logic [NW-1:0] HEAD_BASE = NW'(NUM_PAGES);

   // configuration
   logic [SHIFT_W-1:0] ps_ff, ps_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [MAXO_W-1:0]  maxo_ff, maxo_in;

   // control state
   logic [PW-1:0]      clr_ff, clr_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]      hf_ff [MAX_ORDER+1];
   logic [NW-1:0]      hf_in [MAX_ORDER+1];
   logic [NW-1:0]      hb_ff [MAX_ORDER+1];
   logic [NW-1:0]      hb_in [MAX_ORDER+1];
   logic               rv_ff, rv_in;

   // working registers
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [ADDR_W-1:0]  size_ff, size_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  v_ff, v_in;
   logic               lt_ff, lt_in;
   logic               idx_ok_ff, idx_ok_in;
   logic [OW-1:0]      j_ff, j_in;
   logic [OW-1:0]      k_ff, k_in;
   logic [PW-1:0]      idx_ff, idx_in;
   logic [BW-1:0]      bud_ff, bud_in;
   logic [PW-1:0]      pn_ff, pn_in;
   logic [NW-1:0]      first_ff, first_in;
   logic               st_ff, st_in;
   logic [ADDR_W-1:0]  gr_ff, gr_in;
   logic [ADDR_W-1:0]  fr_ff, fr_in;
   logic               ost_ff, ost_in;
   logic [ADDR_W-1:0]  ogr_ff, ogr_in;
   logic [ADDR_W-1:0]  ofr_ff, ofr_in;
   logic [COUNT_W-1:0] ocnt_ff, ocnt_in;

   // memories
   logic          tag_we;
   logic [PW-1:0] tag_waddr, tag_raddr;
   logic [TW-1:0] tag_wdata, tag_q;
   logic          fwd_we, bwd_we;
   logic [PW-1:0] fwd_waddr, bwd_waddr, link_raddr;
   logic [NW-1:0] fwd_wdata, bwd_wdata, fwd_q, bwd_q;

   logic [OW-1:0]     top;
   logic [BW-1:0]     bud_pb, split_bud;
   logic [ADDR_W-1:0] p_full;
   logic              tag_free;
   logic [OW-1:0]     tag_ord;
   logic [31:0]       k_pages, cnt_sum;
   logic [63:0]       gr_wide;

   bpa_ram #(.WIDTH(TW), .DEPTH(NUM_PAGES)) u_tag_ram (
      .clock(clock), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
      .raddr(tag_raddr), .rdata(tag_q));

   bpa_ram #(.WIDTH(NW), .DEPTH(NUM_PAGES)) u_fwd_ram (
      .clock(clock), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
      .raddr(link_raddr), .rdata(fwd_q));

   bpa_ram #(.WIDTH(NW), .DEPTH(NUM_PAGES)) u_bwd_ram (
      .clock(clock), .we(bwd_we), .waddr(bwd_waddr), .wdata(bwd_wdata),
      .raddr(link_raddr), .rdata(bwd_q));

   assign top       = (maxo_ff > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(maxo_ff);
   assign bud_pb    = BW'(idx_ff) ^ (BW'(1) << k_ff);
   assign split_bud = BW'(idx_ff) + (BW'(1) << (j_ff - OW'(1)));
   assign p_full    = v_ff >> ps_ff;
   assign tag_free  = tag_q[OW];
   assign tag_ord   = tag_q[OW-1:0];
   assign k_pages   = 32'(1) << k_ff;
   assign cnt_sum   = 32'(cnt_ff) + k_pages;
   assign gr_wide   = 64'(base_ff) + (64'(idx_ff) << ps_ff);

   always_comb begin
      status.clear_last = (clr_ff == PW'(NUM_PAGES - 1));
      status.v_zero     = (v_ff == '0);
      status.j_at_top   = (j_ff >= top);
      status.j_eq_k     = (j_ff == k_ff);
      status.head_ne    = (hf_ff[j_ff] != (HEAD_BASE + NW'(j_ff)));
      status.idx_ok     = idx_ok_ff;
      status.tag_free   = tag_free;
      status.merge_ok   = tag_free && (tag_ord == k_ff);
      status.pb_stop    = (k_ff >= top) || (bud_pb >= BW'(NUM_PAGES));
      status.bud_ok     = (bud_ff < BW'(NUM_PAGES));
      status.out_free   = !rv_ff || rsp_ready;
      status.mode       = mode_ff;
   end

   always_comb begin
      ps_in     = ps_ff;
      base_in   = base_ff;
      maxo_in   = maxo_ff;
      clr_in    = clr_ff;
      cnt_in    = cnt_ff;
      hf_in     = hf_ff;
      hb_in     = hb_ff;
      rv_in     = rv_ff;
      mode_in   = mode_ff;
      size_in   = size_ff;
      addr_in   = addr_ff;
      v_in      = v_ff;
      lt_in     = lt_ff;
      idx_ok_in = idx_ok_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      idx_in    = idx_ff;
      bud_in    = bud_ff;
      pn_in     = pn_ff;
      first_in  = first_ff;
      st_in     = st_ff;
      gr_in     = gr_ff;
      fr_in     = fr_ff;
      ost_in    = ost_ff;
      ogr_in    = ogr_ff;
      ofr_in    = ofr_ff;
      ocnt_in   = ocnt_ff;

      tag_we     = 1'b0;
      tag_waddr  = idx_ff;
      tag_wdata  = '0;
      tag_raddr  = idx_ff;
      fwd_we     = 1'b0;
      fwd_waddr  = idx_ff;
      fwd_wdata  = '0;
      bwd_we     = 1'b0;
      bwd_waddr  = idx_ff;
      bwd_wdata  = '0;
      link_raddr = idx_ff;

      if (csr_valid) begin
         unique case (csr_reg_index)
            REG_PAGE_SHIFT: ps_in   = csr_wdata[SHIFT_W-1:0];
            REG_BASE_ADDR:  base_in = csr_wdata;
            REG_MAX_ORDER:  maxo_in = csr_wdata[MAXO_W-1:0];
            default:        ;
         endcase
      end

      if (rv_ff && rsp_ready) rv_in = 1'b0;

      case (cmd)
         CMD_CLEAR: begin
            tag_we    = 1'b1;
            tag_waddr = clr_ff;
            clr_in    = clr_ff + PW'(1);
         end
         CMD_LOAD: begin
            mode_in = req_mode;
            size_in = req_request_bytes;
            addr_in = req_address;
            st_in   = 1'b0;
            gr_in   = '0;
            fr_in   = '0;
            j_in    = '0;
         end
         CMD_PREP:        v_in = (size_ff == '0) ? '0 : size_ff - ADDR_W'(1);
         CMD_SHIFT:       v_in = p_full;
         CMD_ORDER_STEP: begin
            v_in = v_ff >> 1;
            j_in = j_ff + OW'(1);
         end
         CMD_SET_K:       k_in = j_ff;
         CMD_SEARCH_NEXT: j_in = j_ff + OW'(1);
         CMD_SEARCH_HIT:  idx_in = hb_ff[j_ff][PW-1:0];
         CMD_TAKE_RD:     link_raddr = idx_ff;
         CMD_TAKE_WR, CMD_PB_MERGE: begin
            // take the node out of its list
            if (bwd_q >= HEAD_BASE) begin
               hf_in[OW'(bwd_q - HEAD_BASE)] = fwd_q;
            end else begin
               fwd_we    = 1'b1;
               fwd_waddr = bwd_q[PW-1:0];
               fwd_wdata = fwd_q;
            end
            if (fwd_q >= HEAD_BASE) begin
               hb_in[OW'(fwd_q - HEAD_BASE)] = bwd_q;
            end else begin
               bwd_we    = 1'b1;
               bwd_waddr = fwd_q[PW-1:0];
               bwd_wdata = bwd_q;
            end
            tag_we = 1'b1;
            if (cmd == CMD_TAKE_WR) begin
               tag_waddr = idx_ff;
               tag_wdata = {1'b0, k_ff};
            end else begin
               tag_waddr = bud_ff[PW-1:0];
               tag_wdata = {1'b0, tag_ord};
               k_in      = k_ff + OW'(1);
               if (bud_ff < BW'(idx_ff)) idx_in = bud_ff[PW-1:0];
            end
         end
         CMD_SPLIT_STEP: begin
            j_in   = j_ff - OW'(1);
            bud_in = split_bud;
            pn_in  = split_bud[PW-1:0];
         end
         CMD_PUSH_A: begin
            first_in   = hf_ff[j_ff];
            hf_in[j_ff] = NW'(pn_ff);
            fwd_we     = 1'b1;
            fwd_waddr  = pn_ff;
            fwd_wdata  = hf_ff[j_ff];
            bwd_we     = 1'b1;
            bwd_waddr  = pn_ff;
            bwd_wdata  = HEAD_BASE + NW'(j_ff);
            tag_we     = 1'b1;
            tag_waddr  = pn_ff;
            tag_wdata  = {1'b1, j_ff};
         end
         CMD_PUSH_B: begin
            if (first_ff >= HEAD_BASE) begin
               hb_in[OW'(first_ff - HEAD_BASE)] = NW'(pn_ff);
            end else begin
               bwd_we    = 1'b1;
               bwd_waddr = first_ff[PW-1:0];
               bwd_wdata = NW'(pn_ff);
            end
         end
         CMD_IDX_SUB: begin
            v_in  = addr_ff - base_ff;
            lt_in = (addr_ff < base_ff);
         end
         CMD_IDX_SHIFT: begin
            idx_in    = p_full[PW-1:0];
            idx_ok_in = !lt_ff && (p_full < ADDR_W'(NUM_PAGES));
         end
         CMD_TAG_RD:      tag_raddr = idx_ff;
         CMD_ALIGN: begin
            k_in   = tag_ord;
            idx_in = idx_ff & ({PW{1'b1}} << tag_ord);
         end
         CMD_K_LOAD:      k_in = tag_ord;
         CMD_K_ZERO:      k_in = '0;
         CMD_PB_START: begin
            cnt_in = (cnt_sum > 32'(COUNT_MAX)) ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
            if (mode_ff == MODE_FREE) begin
               fr_in = ADDR_W'(64'(1) << (7'(k_ff) + 7'(ps_ff)));
            end
         end
         CMD_PB_RD: begin
            bud_in     = bud_pb;
            tag_raddr  = bud_pb[PW-1:0];
            link_raddr = bud_pb[PW-1:0];
         end
         CMD_PB_SET: begin
            pn_in = idx_ff;
            j_in  = k_ff;
         end
         CMD_RES_OK: begin
            cnt_in = (k_pages >= 32'(cnt_ff)) ? '0 : cnt_ff - k_pages[COUNT_W-1:0];
            gr_in  = gr_wide[ADDR_W-1:0];
         end
         CMD_FAIL:        st_in = 1'b1;
         CMD_EMIT: begin
            rv_in   = 1'b1;
            ost_in  = st_ff;
            ogr_in  = gr_ff;
            ofr_in  = fr_ff;
            ocnt_in = cnt_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff   <= SHIFT_W'(12);
         base_ff <= '0;
         maxo_ff <= MAXO_W'(12);
         clr_ff  <= '0;
         cnt_ff  <= '0;
         rv_ff   <= 1'b0;
         for (int i = 0; i <= MAX_ORDER; i++) begin
            hf_ff[i] <= HEAD_BASE + NW'(i);
            hb_ff[i] <= HEAD_BASE + NW'(i);
         end
      end else begin
         ps_ff   <= ps_in;
         base_ff <= base_in;
         maxo_ff <= maxo_in;
         clr_ff  <= clr_in;
         cnt_ff  <= cnt_in;
         rv_ff   <= rv_in;
         hf_ff   <= hf_in;
         hb_ff   <= hb_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      size_ff   <= size_in;
      addr_ff   <= addr_in;
      v_ff      <= v_in;
      lt_ff     <= lt_in;
      idx_ok_ff <= idx_ok_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      idx_ff    <= idx_in;
      bud_ff    <= bud_in;
      pn_ff     <= pn_in;
      first_ff  <= first_in;
      st_ff     <= st_in;
      gr_ff     <= gr_in;
      fr_ff     <= fr_in;
      ost_ff    <= ost_in;
      ogr_ff    <= ogr_in;
      ofr_ff    <= ofr_in;
      ocnt_ff   <= ocnt_in;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_status          = ost_ff;
   assign rsp_granted_address = ogr_ff;
   assign rsp_freed_bytes     = ofr_ff;
   assign rsp_free_pages      = ocnt_ff;
endmodule

@@ test/testbench.sv @@
module testbench;
   import bpa_pkg::*;

   localparam int NPAGES  = 4096;
   localparam int TOP_ORD = 12;
   localparam int NODES   = NPAGES + TOP_ORD + 1;
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
   localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 100;

   typedef struct packed {
      logic               status;
      logic [ADDR_W-1:0]  granted_address;
      logic [ADDR_W-1:0]  freed_bytes;
      logic [COUNT_W-1:0] free_pages;
   } reply_type;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] bytes;
      logic [ADDR_W-1:0] addr;
      bit                typed;
      reply_type         reply;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpa_req_if req_bus ();
   bpa_rsp_if rsp_bus ();
   bpa_csr_if csr_bus ();

   buddy_page_allocator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the allocator state
   bit              page_free [NPAGES];
   bit [4:0]        page_ord  [NPAGES];
   int unsigned     link_fwd  [NODES];
   int unsigned     link_bwd  [NODES];
   int unsigned     free_count;
   int unsigned     shadow_shift;
   logic [63:0]     shadow_base;
   int unsigned     shadow_maxo;

   reply_type       expected_replies [$];
   logic [ADDR_W-1:0] granted_pool [$];
   int              errors = 0;
   bit              calm = 0;
   int              quiet_cycles = 0;

   function automatic int unsigned top_order();
      return (shadow_maxo > 32'(TOP_ORD)) ? 32'(TOP_ORD) : shadow_maxo;
   endfunction

   function automatic void count_up(longint unsigned n);
      longint unsigned c;
      c = 64'(free_count) + n;
      free_count = (c > 64'(COUNT_MAX)) ? 32'(COUNT_MAX) : 32'(c);
   endfunction

   function automatic void unlink(int unsigned n);
      int unsigned f, b;
      f = link_fwd[n];
      b = link_bwd[n];
      link_fwd[b] = f;
      link_bwd[f] = b;
   endfunction

   function automatic void push_front(int unsigned j, int unsigned n);
      int unsigned h, first;
      h = NPAGES + j;
      first = link_fwd[h];
      link_fwd[n] = first;
      link_bwd[n] = h;
      link_bwd[first] = n;
      link_fwd[h] = n;
   endfunction

   // return a block to the free lists, merging upward with free buddies
   function automatic void release_block(int unsigned idx, int unsigned k);
      int unsigned top, bud;
      top = top_order();
      count_up(64'd1 << k);
      while (k < top) begin
         bud = idx ^ (32'd1 << k);
         if (bud >= NPAGES || !page_free[bud] || 32'(page_ord[bud]) != k) break;
         unlink(bud);
         page_free[bud] = 0;
         k++;
         if (bud < idx) idx = bud;
      end
      page_free[idx] = 1;
      page_ord[idx] = 5'(k);
      push_front(k, idx);
   endfunction

   function automatic bit to_page(logic [63:0] addr, output int unsigned idx);
      logic [63:0] p;
      idx = 0;
      if (addr < shadow_base) return 0;
      p = (addr - shadow_base) >> shadow_shift;
      if (p >= 64'(NPAGES)) return 0;
      idx = 32'(p);
      return 1;
   endfunction

   function automatic void shadow_reset();
      for (int i = 0; i < NPAGES; i++) begin
         page_free[i] = 0;
         page_ord[i] = 0;
         link_fwd[i] = 0;
         link_bwd[i] = 0;
      end
      for (int i = 0; i <= TOP_ORD; i++) begin
         link_fwd[NPAGES + i] = NPAGES + i;
         link_bwd[NPAGES + i] = NPAGES + i;
      end
      free_count = 0;
      shadow_shift = 12;
      shadow_base = 0;
      shadow_maxo = 12;
   endfunction

   // works out the reply of one request and updates the shadow state
   function automatic reply_type predict_allocation(logic [MODE_W-1:0] mode,
                                                    logic [63:0] bytes, logic [63:0] addr);
      reply_type r;
      longint unsigned pages;
      int unsigned k, j, s, top, blk, bud, idx;
      bit found;
      r = '0;
      if (mode == MODE_RESERVE) begin
         pages = (bytes == 0) ? 64'd1 : ((bytes - 64'd1) >> shadow_shift) + 64'd1;
         k = 0;
         top = top_order();
         found = 0;
         while (k < 63 && (64'd1 << k) < pages) k++;
         for (j = k; j <= top && !found; j++) begin
            if (link_fwd[NPAGES + j] != NPAGES + j) begin
               blk = link_bwd[NPAGES + j];
               unlink(blk);
               page_free[blk] = 0;
               page_ord[blk] = 5'(j);
               // split off upper buddies down to the asked order
               s = j;
               while (s > k) begin
                  s--;
                  bud = blk + (32'd1 << s);
                  page_ord[blk] = 5'(s);
                  if (bud < NPAGES) begin
                     page_free[bud] = 1;
                     page_ord[bud] = 5'(s);
                     push_front(s, bud);
                  end
               end
               free_count = ((64'd1 << k) >= 64'(free_count)) ? 32'd0 :
                            free_count - (32'd1 << k);
               r.granted_address =
                  ADDR_W'((shadow_base + (64'(blk) << shadow_shift)) & MASK48);
               found = 1;
            end
         end
         if (!found) r.status = 1'b1;
         else granted_pool.push_back(r.granted_address);
      end else if (mode == MODE_FREE) begin
         if (to_page(addr, idx) && !page_free[idx]) begin
            k = (page_ord[idx] > 5'(TOP_ORD)) ? 32'(TOP_ORD) : 32'(page_ord[idx]);
            idx &= ~((32'd1 << k) - 32'd1);
            if (!page_free[idx]) begin
               k = (page_ord[idx] > 5'(TOP_ORD)) ? 32'(TOP_ORD) : 32'(page_ord[idx]);
               release_block(idx, k);
               r.freed_bytes = ADDR_W'(((64'd1 << k) << shadow_shift) & MASK48);
            end
         end
      end else if (mode == MODE_ADD) begin
         if (to_page(addr, idx) && !page_free[idx]) release_block(idx, 0);
      end
      r.free_pages = COUNT_W'(free_count);
      return r;
   endfunction

   // request side: hold the transaction until taken, then maybe idle
   task automatic issue(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] bytes,
                        logic [ADDR_W-1:0] addr, bit typed, reply_type typed_reply);
      reply_type r;
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.request_bytes <= bytes;
      req_bus.address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      r = predict_allocation(mode, 64'(bytes), 64'(addr));
      expected_replies.push_back(typed ? typed_reply : r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // register write while idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [ADDR_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wdata <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (index)
         REG_PAGE_SHIFT: shadow_shift = 32'(value[4:0]);
         REG_BASE_ADDR:  shadow_base = 64'(value);
         REG_MAX_ORDER:  shadow_maxo = 32'(value[3:0]);
         default: ;
      endcase
   endtask

   function automatic logic [ADDR_W-1:0] wide_rand();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [ADDR_W-1:0] page_addr(int unsigned idx);
      return ADDR_W'((shadow_base + (64'(idx) << shadow_shift)) & MASK48);
   endfunction

   // one random request, mostly well-formed traffic over the given page window
   task automatic random_request(int unsigned window);
      int unsigned pick, p;
      logic [ADDR_W-1:0] bytes, addr;
      logic [MODE_W-1:0] mode;
      pick = $urandom_range(0, 99);
      bytes = wide_rand();
      addr = wide_rand();
      if (pick < 36) begin
         mode = MODE_ADD;
         if (pick >= 3) addr = page_addr($urandom_range(0, window - 1));
         if (pick == 3) addr = page_addr($urandom_range(0, NPAGES - 1));
      end else if (pick < 70) begin
         mode = MODE_RESERVE;
         if (pick < 66) begin
            bytes = ADDR_W'((64'd1 << $urandom_range(0, 4)) << shadow_shift);
            bytes = bytes - ADDR_W'($urandom_range(0, 3));
         end
         if (pick == 66) bytes = 0;
      end else if (pick < 97) begin
         mode = MODE_FREE;
         if (pick < 93 && granted_pool.size() != 0) begin
            p = $urandom_range(0, granted_pool.size() - 1);
            addr = granted_pool[p];
            granted_pool.delete(p);
            // possibly unaligned free: point up to three pages past the block start
            if (pick > 86)
               addr = addr + ADDR_W'((64'd1 << shadow_shift) * $urandom_range(0, 3));
         end else if (pick < 95) begin
            addr = page_addr($urandom_range(0, window - 1));
         end
      end else begin
         mode = MODE_NONE;
      end
      issue(mode, bytes, addr, 1'b0, '0);
   endtask

   // reply side: ready in random bursts, always high near the end
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!calm) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   // compare every reply transaction with the oldest expectation
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            $error("reply with no request outstanding");
            errors++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               errors++;
            end
            if (rsp_bus.granted_address !== want.granted_address) begin
               $error("granted_address: expected %h, got %h",
                      want.granted_address, rsp_bus.granted_address);
               errors++;
            end
            if (rsp_bus.freed_bytes !== want.freed_bytes) begin
               $error("freed_bytes: expected %h, got %h",
                      want.freed_bytes, rsp_bus.freed_bytes);
               errors++;
            end
            if (rsp_bus.free_pages !== want.free_pages) begin
               $error("free_pages: expected %0d, got %0d",
                      want.free_pages, rsp_bus.free_pages);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // directed rows, typed replies only where obvious
   row_type directed [] = '{
      '{MODE_RESERVE, 48'd0,          48'd0,           1, '{1'b1, 48'd0, 48'd0, 13'd0}},
      '{MODE_FREE,    48'd0,          48'd0,           1, '{1'b0, 48'd0, 48'd4096, 13'd1}},
      '{MODE_ADD,     48'd0,          48'd0,           1, '{1'b0, 48'd0, 48'd0, 13'd1}},
      '{MODE_ADD,     48'd0,          48'd4096,        0, '0},
      '{MODE_NONE,    48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1,
        '{1'b0, 48'd0, 48'd0, 13'd2}},
      '{MODE_ADD,     48'd0,          48'hFFFF_FFFF_FFFF, 1, '{1'b0, 48'd0, 48'd0, 13'd2}},
      '{MODE_RESERVE, 48'hFFFF_FFFF_FFFF, 48'd0,       0, '0},
      '{MODE_RESERVE, 48'd0,          48'd0,           0, '0},
      '{MODE_FREE,    48'd0,          48'd4096,        0, '0},
      '{MODE_ADD,     48'd0,          48'd4095 << 12,  0, '0},
      '{MODE_ADD,     48'd0,          48'd4094 << 12,  0, '0},
      '{MODE_ADD,     48'd0,          48'd4094 << 12,  0, '0},
      '{MODE_RESERVE, 48'd8192,       48'd0,           0, '0},
      '{MODE_FREE,    48'd0,          (48'd4095 << 12) + 48'd5, 0, '0},
      '{MODE_RESERVE, 48'd1,          48'd0,           0, '0},
      '{MODE_RESERVE, 48'd4097,       48'd0,           0, '0},
      '{MODE_FREE,    48'd0,          48'd4094 << 12,  0, '0},
      '{MODE_FREE,    48'd0,          48'd4094 << 12,  0, '0},
      '{MODE_ADD,     48'd0,          48'd4096 << 12,  0, '0},
      '{MODE_RESERVE, 48'd16384,      48'd0,           0, '0}
   };

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_RESERVE;
      req_bus.request_bytes <= '0;
      req_bus.address <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.reg_index <= REG_PAGE_SHIFT;
      csr_bus.wdata <= '0;
      shadow_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         issue(directed[i].mode, directed[i].bytes, directed[i].addr,
               directed[i].typed, directed[i].reply);

      // phases of register settings, extremes among them
      write_reg(REG_MAX_ORDER, 48'd3);
      repeat (250) random_request(64);
      write_reg(REG_PAGE_SHIFT, 48'd0);
      write_reg(REG_BASE_ADDR, 48'hFFFF_FFFF_F000);
      write_reg(REG_MAX_ORDER, 48'd0);
      repeat (150) random_request(64);
      write_reg(REG_PAGE_SHIFT, 48'd30);
      write_reg(REG_BASE_ADDR, 48'h0000_0012_3400);
      write_reg(REG_MAX_ORDER, 48'd15);
      repeat (250) random_request(4096);
      write_reg(REG_PAGE_SHIFT, 48'd31);
      write_reg(REG_BASE_ADDR, 48'd0);
      write_reg(REG_MAX_ORDER, 48'd12);
      repeat (150) random_request(32);
      write_reg(REG_PAGE_SHIFT, 48'd7);
      write_reg(REG_BASE_ADDR, wide_rand() & 48'h0FFF_FFFF_FFFF);
      write_reg(REG_MAX_ORDER, 48'd6);
      repeat (300) random_request(128);
      // last stretch without idling on either side
      calm = 1;
      repeat (150) random_request(128);
      req_bus.valid <= 1'b0;

      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
